FILE: rtl/core/bitmap_block_allocator_core_defines.svh
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// property that must hold at every edge out of reset
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bba_pkg.sv
// shared types, codes and helpers of the bitmap block allocator
package bba_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned MAP_W   = 2;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;

  // opcodes
  localparam logic [OP_W-1:0] OP_READ    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET     = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  // map selects
  localparam logic [MAP_W-1:0] MAP_FOLDER = 2'd0;
  localparam logic [MAP_W-1:0] MAP_FILE   = 2'd1;
  localparam logic [MAP_W-1:0] MAP_BLOCK  = 2'd2;
  localparam logic [MAP_W-1:0] MAP_NONE   = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_LIMIT = 3'd3;
  localparam logic [ST_W-1:0] ST_MAP   = 3'd4;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic               bit_value;
    logic [IDX_W-1:0]   granted_index;
    logic [COUNT_W-1:0] used_count;
  } rsp_t;

  // returns {found, position of lowest clear bit}
  function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = {1'b1, BIT_W'(i)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/bba_req_if.sv
// request channel: opcode, map select and bit index
interface bba_req_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::OP_W-1:0]   opcode;
  logic [bba_pkg::MAP_W-1:0]  map_select;
  logic [bba_pkg::IDX_W-1:0]  index;

  modport source (output valid, opcode, map_select, index, input ready);
  modport sink   (input valid, opcode, map_select, index, output ready);
endinterface

FILE: rtl/core/bba_rsp_if.sv
// response channel: status, bit read, granted index and used count
interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::ST_W-1:0]     status;
  logic                         bit_value;
  logic [bba_pkg::IDX_W-1:0]    granted_index;
  logic [bba_pkg::COUNT_W-1:0]  used_count;

  modport source (output valid, status, bit_value, granted_index, used_count, input ready);
  modport sink   (input valid, status, bit_value, granted_index, used_count, output ready);
endinterface

FILE: rtl/core/bitmap_block_allocator_core.sv
// bitmap block allocator: three bitmaps in one word memory plus used counters
//
// channel | dir | word contents                               | handshake
// --------+-----+---------------------------------------------+-------------
// req_i   | in  | opcode, map_select, index                   | valid/ready
// rsp_o   | out | status, bit_value, granted_index, used_count | valid/ready
//
// one request in flight; ready is high in idle even while a response waits
// bad map, release, unused opcodes, range errors: answered without a memory access
// read, set, clear: one memory read, then the response with write-back (set, clear)
// allocate: scans one word per cycle, stopping at the word with the lowest free bit
// after reset a clearing pass zeroes every folder, file and block word of the memory
// a stalled response holds the engine before its write-back; nothing is lost
`include "bitmap_block_allocator_core_defines.svh"

module bitmap_block_allocator_core #(
  parameter int unsigned FOLDER_ENTRIES = 32,
  parameter int unsigned FILE_ENTRIES   = 256,
  parameter int unsigned DATA_BLOCKS    = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);
  import bba_pkg::*;

  // memory layout: folder word, then file words, then block words
  localparam int unsigned FILE_WORDS  = (FILE_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int unsigned BLOCK_WORDS = (DATA_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned TOTAL_WORDS = 1 + FILE_WORDS + BLOCK_WORDS;
  localparam int unsigned AW          = $clog2(TOTAL_WORDS);
  localparam int unsigned FILE_BASE   = 1;
  localparam int unsigned BLOCK_BASE  = 1 + FILE_WORDS;
  localparam int unsigned MAX_WORDS   = (FILE_WORDS > BLOCK_WORDS) ? FILE_WORDS : BLOCK_WORDS;
  localparam int unsigned SW          = $clog2(MAX_WORDS + 1);

  // valid bits of the last word of each map
  localparam int unsigned FILE_REM  = FILE_ENTRIES - WORD_W * (FILE_WORDS - 1);
  localparam int unsigned BLOCK_REM = DATA_BLOCKS - WORD_W * (BLOCK_WORDS - 1);
  localparam logic [WORD_W-1:0] FOLDER_TAIL = {WORD_W{1'b1}} >> (WORD_W - FOLDER_ENTRIES);
  localparam logic [WORD_W-1:0] FILE_TAIL   = {WORD_W{1'b1}} >> (WORD_W - FILE_REM);
  localparam logic [WORD_W-1:0] BLOCK_TAIL  = {WORD_W{1'b1}} >> (WORD_W - BLOCK_REM);

  // counter widths
  localparam int unsigned FOLDER_CW = $clog2(FOLDER_ENTRIES + 1);
  localparam int unsigned FILE_CW   = $clog2(FILE_ENTRIES + 1);
  localparam int unsigned BLOCK_CW  = $clog2(DATA_BLOCKS + 1);

  // engine states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_BIT   = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;

  logic [2:0] state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  // captured request
  logic [OP_W-1:0]  op_q;
  logic [MAP_W-1:0] map_q;
  logic [IDX_W-1:0] idx_q;

  // allocate scan: next word to read, and which word sits in the read register
  logic [SW-1:0] scan_q, scan_d;
  logic [SW-1:0] chk_idx_q, chk_idx_d;
  logic          chk_vld_q, chk_vld_d;

  // used counters
  logic [FOLDER_CW-1:0] folder_cnt_q, folder_cnt_d;
  logic [FILE_CW-1:0]   file_cnt_q, file_cnt_d;
  logic [BLOCK_CW-1:0]  block_cnt_q, block_cnt_d;

  // response register
  logic out_vld_q, out_vld_d;
  rsp_t out_q, out_d;
  logic out_load, out_free;

  // bitmap memory
  logic [WORD_W-1:0] mem [TOTAL_WORDS];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, rdata_q;

  // selected map
  logic [AW-1:0]      sel_base;
  logic [SW-1:0]      sel_words;
  logic [WORD_W-1:0]  sel_tail;
  logic [COUNT_W-1:0] sel_size, sel_count;

  // count update
  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_new;

  // scan helpers
  logic              chk_last;
  logic [WORD_W-1:0] chk_masked;
  logic [BIT_W:0]    zero_hit;
  logic [BIT_W-1:0]  bit_pos;

  always_comb begin
    sel_base  = '0;
    sel_words = '0;
    sel_tail  = '0;
    sel_size  = '0;
    sel_count = '0;
    case (map_q)
      MAP_FOLDER: begin
        sel_base  = '0;
        sel_words = SW'(1);
        sel_tail  = FOLDER_TAIL;
        sel_size  = COUNT_W'(FOLDER_ENTRIES);
        sel_count = COUNT_W'(folder_cnt_q);
      end
      MAP_FILE: begin
        sel_base  = AW'(FILE_BASE);
        sel_words = SW'(FILE_WORDS);
        sel_tail  = FILE_TAIL;
        sel_size  = COUNT_W'(FILE_ENTRIES);
        sel_count = COUNT_W'(file_cnt_q);
      end
      MAP_BLOCK: begin
        sel_base  = AW'(BLOCK_BASE);
        sel_words = SW'(BLOCK_WORDS);
        sel_tail  = BLOCK_TAIL;
        sel_size  = COUNT_W'(DATA_BLOCKS);
        sel_count = COUNT_W'(block_cnt_q);
      end
      default: ;
    endcase
  end

  // bits past the end of the map read as taken
  assign chk_last   = (chk_idx_q == sel_words - SW'(1));
  assign chk_masked = rdata_q | ~(chk_last ? sel_tail : {WORD_W{1'b1}});
  assign zero_hit   = lowest_zero(chk_masked);
  assign bit_pos    = idx_q[BIT_W-1:0];

  assign out_free = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    scan_d    = scan_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = chk_vld_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    out_d     = '0;
    cnt_we    = 1'b0;
    cnt_new   = sel_count;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(TOTAL_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (req_i.valid) state_d = S_EXEC;
      end

      S_EXEC: begin
        out_d.used_count = sel_count;
        if (map_q == MAP_NONE) begin
          out_d.status     = ST_MAP;
          out_d.used_count = '0;
          out_load         = out_free;
        end else begin
          case (op_q)
            OP_READ, OP_SET, OP_CLEAR: begin
              if ({1'b0, idx_q} >= sel_size) begin
                out_d.status = ST_RANGE;
                out_load     = out_free;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = sel_base + AW'(idx_q >> BIT_W);
                state_d   = S_BIT;
              end
            end
            OP_ALLOC: begin
              scan_d    = '0;
              chk_vld_d = 1'b0;
              state_d   = S_ALLOC;
            end
            OP_RELEASE: begin
              if (sel_count == '0) begin
                out_d.status = ST_LIMIT;
              end else begin
                cnt_new          = sel_count - COUNT_W'(1);
                out_d.used_count = cnt_new;
                cnt_we           = out_free;
              end
              out_load = out_free;
            end
            default: out_load = out_free;
          endcase
        end
        if (out_load) state_d = S_IDLE;
      end

      S_BIT: begin
        out_d.used_count = sel_count;
        out_d.bit_value  = (op_q == OP_READ) ? rdata_q[bit_pos] : 1'b0;
        if (out_free) begin
          out_load  = 1'b1;
          mem_we    = (op_q != OP_READ);
          mem_waddr = sel_base + AW'(idx_q >> BIT_W);
          mem_wdata = rdata_q;
          mem_wdata[bit_pos] = (op_q == OP_SET);
          state_d   = S_IDLE;
        end
      end

      S_ALLOC: begin
        out_d.used_count = sel_count;
        if (chk_vld_q && (zero_hit[BIT_W] || chk_last)) begin
          if (zero_hit[BIT_W]) begin
            out_d.granted_index = IDX_W'({chk_idx_q, zero_hit[BIT_W-1:0]});
            if (sel_count >= sel_size) begin
              out_d.status = ST_LIMIT;
            end else begin
              cnt_new          = sel_count + COUNT_W'(1);
              out_d.used_count = cnt_new;
              cnt_we           = out_free;
            end
            mem_we    = out_free;
            mem_waddr = sel_base + AW'(chk_idx_q);
            mem_wdata = rdata_q;
            mem_wdata[zero_hit[BIT_W-1:0]] = 1'b1;
          end else begin
            out_d.status = ST_FULL;
          end
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (scan_q < sel_words) begin
          // stream the next word while the current one is checked
          mem_re    = 1'b1;
          mem_raddr = sel_base + AW'(scan_q);
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q;
          scan_d    = scan_q + SW'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // counter write-back into the selected map
  always_comb begin
    folder_cnt_d = folder_cnt_q;
    file_cnt_d   = file_cnt_q;
    block_cnt_d  = block_cnt_q;
    if (cnt_we) begin
      case (map_q)
        MAP_FOLDER: folder_cnt_d = FOLDER_CW'(cnt_new);
        MAP_FILE:   file_cnt_d   = FILE_CW'(cnt_new);
        MAP_BLOCK:  block_cnt_d  = BLOCK_CW'(cnt_new);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load)         out_vld_d = 1'b1;
    else if (rsp_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      scan_q       <= '0;
      chk_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      folder_cnt_q <= '0;
      file_cnt_q   <= '0;
      block_cnt_q  <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      scan_q       <= scan_d;
      chk_idx_q    <= chk_idx_d;
      chk_vld_q    <= chk_vld_d;
      folder_cnt_q <= folder_cnt_d;
      file_cnt_q   <= file_cnt_d;
      block_cnt_q  <= block_cnt_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // request capture and response payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= req_i.opcode;
      map_q <= req_i.map_select;
      idx_q <= req_i.index;
    end
    if (out_load) out_q <= out_d;
  end

  // single-port-style word memory, registered read; write-back lands before any re-read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.bit_value     = out_q.bit_value;
  assign rsp_o.granted_index = out_q.granted_index;
  assign rsp_o.used_count    = out_q.used_count;

  // checks
  `BBA_ASSERT_IMP(a_load_free, out_load, out_free, "response loaded over a pending word")
  `BBA_ASSERT_IMP(a_count_bound, out_load, out_d.used_count <= sel_size, "used count beyond map size")
  `BBA_ASSERT_NXT(a_count_hold, !cnt_we, $stable({folder_cnt_q, file_cnt_q, block_cnt_q}), "counter moved without update")
  `BBA_ASSERT_IMP(a_wb_with_rsp, mem_we && (state_q != S_CLEAR), out_load, "write-back without response")
  `BBA_ASSERT_IMP(a_scan_bound, state_q == S_ALLOC, scan_q <= sel_words, "scan ran past the map")

endmodule
